>>> rtl/sliding_window_anagram_matcher_defines.svh
// ----------------------------------------------------------------------------
// Sliding window anagram matcher - assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_ANAGRAM_MATCHER_DEFINES_SVH
`define SLIDING_WINDOW_ANAGRAM_MATCHER_DEFINES_SVH

// Same-cycle implication
`define SWAM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SWAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/swam_pkg.sv
// ----------------------------------------------------------------------------
// swam_pkg
// Shared types and constants of the sliding window anagram matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swam_pkg;

  // Default sizing
  localparam int SWAM_MAX_PATTERN = 256;
  localparam int SWAM_MAX_TEXT    = 65536;
  localparam int SWAM_ALPHABET    = 26;

  // Field widths
  localparam int REQ_W    = 2;
  localparam int LETTER_W = 5;
  localparam int START_W  = 16;

  // Output queue depth (covers the two pipeline stages, the word being accepted and one waiting word)
  localparam int OQ_DEPTH = 4;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd2;

  // Operation carried down the update pipeline
  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_PATTERN,
    OP_TEXT
  } op_t;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [LETTER_W-1:0] letter;
  } in_word_t;

  typedef struct packed {
    logic [START_W-1:0] start_index;
  } out_word_t;

endpackage

`default_nettype wire

>>> rtl/swam_chan_if.sv
// ----------------------------------------------------------------------------
// swam_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swam_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

>>> rtl/swam_ram.sv
// ----------------------------------------------------------------------------
// swam_ram
// Generic RAM: one write port, RD_PORTS read ports, registered read-first data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swam_ram #(
  parameter int WIDTH    = 8,
  parameter int DEPTH    = 32,
  parameter int RD_PORTS = 1,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                               clk,
  input  wire logic                               wr_en,
  input  wire logic [AW-1:0]                      wr_addr,
  input  wire logic [WIDTH-1:0]                   wr_data,
  input  wire logic [RD_PORTS-1:0][AW-1:0]        rd_addr,
  output      logic [RD_PORTS-1:0][WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read before write: a read of the written entry returns the old word
  always_ff @(posedge clk) begin
    for (int p = 0; p < RD_PORTS; p++) begin
      rd_data[p] <= mem[rd_addr[p]];
    end
  end

endmodule

`default_nettype wire

>>> rtl/sliding_window_anagram_matcher.sv
// ----------------------------------------------------------------------------
// sliding_window_anagram_matcher
// Streams pattern and text letters; reports each window start where the last
// pattern-length text letters are a permutation of the pattern.
// ----------------------------------------------------------------------------
// Usage:
//   in_word  : one word per handshake, req_type (clear / pattern / text) and a
//              letter index. Send a clear, then the pattern letters, then text.
//   out_word : one start_index word for every text letter that closes a
//              matching window; words leave in text order.
// Throughput: one input word per cycle while in_word.ready is high. Every
//   text letter does one read-modify-write on each of two balance RAMs (new
//   letter and the letter leaving the window), so the rate is set by those
//   RAM ports; the leaving letter is read from the window ring RAM in the
//   front stage, and a result word passes s1 and s2 into the output queue.
// Stall: results collect in a four-word output queue; in_word.ready drops
//   when the queue plus the words in flight could fill it, so nothing is lost.
// Reset: rst_n (synchronous) clears counters, pointers, RAM valid bits and
//   the queue; no clearing pass is needed. A clear word does the same for the
//   search state and takes effect for the very next word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_window_anagram_matcher_defines.svh"

module sliding_window_anagram_matcher #(
  parameter int MAX_PATTERN = swam_pkg::SWAM_MAX_PATTERN,
  parameter int MAX_TEXT    = swam_pkg::SWAM_MAX_TEXT,
  parameter int ALPHABET    = swam_pkg::SWAM_ALPHABET
) (
  input wire logic  clk,
  input wire logic  rst_n,
  swam_chan_if.sink   in_word,
  swam_chan_if.source out_word
);

  // Derived widths
  localparam int LAW  = $clog2(ALPHABET);
  localparam int RAW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PCW  = $clog2(MAX_PATTERN + 1);
  localparam int TCW  = $clog2(MAX_TEXT + 1);
  localparam int CW   = (TCW > PCW) ? TCW : PCW;
  localparam int BW   = PCW + 1;
  localparam int NZW  = $clog2(ALPHABET + 1);
  localparam int OQPW = $clog2(swam_pkg::OQ_DEPTH);
  localparam int OQCW = $clog2(swam_pkg::OQ_DEPTH + 1);

  localparam logic signed [BW-1:0] BAL_ONE = BW'(1);
  localparam logic signed [BW-1:0] BAL_NEG = -BAL_ONE;
  localparam logic [OQCW-1:0]      OQ_FULL = OQCW'(swam_pkg::OQ_DEPTH);

  // --------------------------------------------------------------------------
  // Front stage: request decode, counters, ring pointer
  // --------------------------------------------------------------------------
  logic                         in_fire;
  logic [swam_pkg::REQ_W-1:0]   req;
  logic [swam_pkg::LETTER_W-1:0] let_in;
  logic                         let_ok;

  logic [PCW-1:0] pc_r, pc_nxt;
  logic [TCW-1:0] tc_r, tc_nxt, tc_inc;
  logic [RAW-1:0] rp_r, rp_nxt, rp_use;
  logic           ts_r, ts_nxt;

  logic           ring_we;
  logic [0:0][RAW-1:0]                ring_raddr;
  logic [0:0][swam_pkg::LETTER_W-1:0] ring_rdata;

  swam_pkg::op_t                s1_op_r, s1_op_nxt;
  logic [LAW-1:0]               s1_idx_r, s1_idx_nxt;
  logic                         s1_rem_r, s1_rem_nxt;
  logic                         s1_emit_r, s1_emit_nxt;
  logic [swam_pkg::START_W-1:0] s1_start_r, s1_start_nxt;

  assign in_fire = in_word.valid && in_word.ready;
  assign req     = in_word.payload.req_type;
  assign let_in  = in_word.payload.letter;
  assign let_ok  = 32'(let_in) < 32'(ALPHABET);
  assign tc_inc  = tc_r + TCW'(1);

  // Wrap the ring pointer at the pattern length
  always_comb begin
    rp_use = rp_r;
    if (PCW'(rp_r) >= pc_r) begin
      rp_use = '0;
    end
  end

  assign ring_raddr[0] = rp_use;

  // Decode the accepted word
  always_comb begin
    pc_nxt       = pc_r;
    tc_nxt       = tc_r;
    rp_nxt       = rp_r;
    ts_nxt       = ts_r;
    ring_we      = 1'b0;
    s1_op_nxt    = swam_pkg::OP_NONE;
    s1_idx_nxt   = LAW'(let_in);
    s1_rem_nxt   = 1'b0;
    s1_emit_nxt  = 1'b0;
    s1_start_nxt = '0;
    if (in_fire) begin
      case (req)
        swam_pkg::REQ_CLEAR: begin
          pc_nxt    = '0;
          tc_nxt    = '0;
          rp_nxt    = '0;
          ts_nxt    = 1'b0;
          s1_op_nxt = swam_pkg::OP_CLEAR;
        end
        swam_pkg::REQ_PATTERN: begin
          if (let_ok && !ts_r && (pc_r < PCW'(MAX_PATTERN))) begin
            pc_nxt    = pc_r + PCW'(1);
            s1_op_nxt = swam_pkg::OP_PATTERN;
          end
        end
        swam_pkg::REQ_TEXT: begin
          if (let_ok && (tc_r < TCW'(MAX_TEXT))) begin
            ts_nxt = 1'b1;
            tc_nxt = tc_inc;
            if (pc_r != '0) begin
              s1_op_nxt    = swam_pkg::OP_TEXT;
              ring_we      = 1'b1;
              s1_rem_nxt   = CW'(tc_r) >= CW'(pc_r);
              s1_emit_nxt  = CW'(tc_inc) >= CW'(pc_r);
              s1_start_nxt = swam_pkg::START_W'(CW'(tc_inc) - CW'(pc_r));
              if ((PCW'(rp_use) + PCW'(1)) >= pc_r) begin
                rp_nxt = '0;
              end else begin
                rp_nxt = rp_use + RAW'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Window ring: read the leaving letter, write the new one at the same slot
  swam_ram #(
    .WIDTH    (swam_pkg::LETTER_W),
    .DEPTH    (MAX_PATTERN),
    .RD_PORTS (1)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (rp_use),
    .wr_data (let_in),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  // --------------------------------------------------------------------------
  // Read stage: issue balance reads for the new and the leaving letter
  // --------------------------------------------------------------------------
  logic [LAW-1:0] old_idx;
  logic [1:0][LAW-1:0] bal_raddr;
  logic [1:0][BW-1:0]  x_rdata, y_rdata;

  logic [ALPHABET-1:0] vx_r, vx_nxt, vy_r, vy_nxt;

  swam_pkg::op_t                s2_op_r;
  logic [LAW-1:0]               s2_n_r, s2_o_r;
  logic                         s2_rem_r, s2_emit_r;
  logic [swam_pkg::START_W-1:0] s2_start_r;
  logic                         s2_vxn_r, s2_vxo_r, s2_vyn_r, s2_vyo_r;

  assign old_idx      = LAW'(ring_rdata[0]);
  assign bal_raddr[0] = s1_idx_r;
  assign bal_raddr[1] = old_idx;

  // --------------------------------------------------------------------------
  // Update stage: forward, modify, write back, count nonzero balances
  // --------------------------------------------------------------------------
  logic                  wx_en, wy_en, same;
  logic signed [BW-1:0]  xn, xo, yn, yo, dn;
  logic signed [BW-1:0]  bn_old, bn_new, bo_old, bo_new;
  logic signed [BW-1:0]  wx_data, wy_data;
  logic                  n_up, n_dn, o_up, o_dn;
  logic [1:0]            inc, dec;
  logic [NZW-1:0]        nz_r, nz_nxt;

  logic                  clr_prev_r;
  logic                  wx_en_r, wy_en_r;
  logic [LAW-1:0]        wx_addr_r, wy_addr_r;
  logic signed [BW-1:0]  wx_data_r, wy_data_r;

  // Pick the current value of one entry: cleared, forwarded or stored
  function automatic logic signed [BW-1:0] bal_pick(
    input logic [BW-1:0]        ram_q,
    input logic                 vld,
    input logic [LAW-1:0]       addr,
    input logic                 fw_en,
    input logic [LAW-1:0]       fw_addr,
    input logic signed [BW-1:0] fw_data,
    input logic                 clr_prev
  );
    logic signed [BW-1:0] v;
    v = vld ? $signed(ram_q) : '0;
    if (clr_prev) begin
      v = '0;
    end else if (fw_en && (fw_addr == addr)) begin
      v = fw_data;
    end
    return v;
  endfunction

  always_comb begin
    xn = bal_pick(x_rdata[0], s2_vxn_r, s2_n_r, wx_en_r, wx_addr_r, wx_data_r, clr_prev_r);
    xo = bal_pick(x_rdata[1], s2_vxo_r, s2_o_r, wx_en_r, wx_addr_r, wx_data_r, clr_prev_r);
    yn = bal_pick(y_rdata[0], s2_vyn_r, s2_n_r, wy_en_r, wy_addr_r, wy_data_r, clr_prev_r);
    yo = bal_pick(y_rdata[1], s2_vyo_r, s2_o_r, wy_en_r, wy_addr_r, wy_data_r, clr_prev_r);

    dn      = (s2_op_r == swam_pkg::OP_PATTERN) ? BAL_NEG : BAL_ONE;
    wx_en   = (s2_op_r == swam_pkg::OP_PATTERN) || (s2_op_r == swam_pkg::OP_TEXT);
    wy_en   = (s2_op_r == swam_pkg::OP_TEXT) && s2_rem_r;
    same    = wy_en && (s2_n_r == s2_o_r);
    wx_data = xn + dn;
    wy_data = yo + BAL_NEG;

    // Balance is the sum of the add-side and remove-side counts
    bn_old = xn + yn;
    bn_new = bn_old + dn;
    bo_old = xo + yo;
    bo_new = bo_old + BAL_NEG;

    n_up = (bn_old == '0) && (bn_new != '0);
    n_dn = (bn_old != '0) && (bn_new == '0);
    o_up = wy_en && (bo_old == '0) && (bo_new != '0);
    o_dn = wy_en && (bo_old != '0) && (bo_new == '0);
    inc  = 2'(n_up) + 2'(o_up);
    dec  = 2'(n_dn) + 2'(o_dn);

    // A letter that enters and leaves in the same step leaves its balance alone
    nz_nxt = nz_r;
    if (s2_op_r == swam_pkg::OP_CLEAR) begin
      nz_nxt = '0;
    end else if (wx_en && !same) begin
      nz_nxt = nz_r + NZW'(inc) - NZW'(dec);
    end
  end

  // Track which balance entries hold written data
  always_comb begin
    vx_nxt = vx_r;
    vy_nxt = vy_r;
    if (s2_op_r == swam_pkg::OP_CLEAR) begin
      vx_nxt = '0;
      vy_nxt = '0;
    end else begin
      if (wx_en) begin
        vx_nxt[s2_n_r] = 1'b1;
      end
      if (wy_en) begin
        vy_nxt[s2_o_r] = 1'b1;
      end
    end
  end

  // Add side: pattern letters subtract, text letters add
  swam_ram #(
    .WIDTH    (BW),
    .DEPTH    (ALPHABET),
    .RD_PORTS (2)
  ) u_add_ram (
    .clk     (clk),
    .wr_en   (wx_en),
    .wr_addr (s2_n_r),
    .wr_data (wx_data),
    .rd_addr (bal_raddr),
    .rd_data (x_rdata)
  );

  // Remove side: letters leaving the window
  swam_ram #(
    .WIDTH    (BW),
    .DEPTH    (ALPHABET),
    .RD_PORTS (2)
  ) u_rem_ram (
    .clk     (clk),
    .wr_en   (wy_en),
    .wr_addr (s2_o_r),
    .wr_data (wy_data),
    .rd_addr (bal_raddr),
    .rd_data (y_rdata)
  );

  // --------------------------------------------------------------------------
  // Output queue
  // --------------------------------------------------------------------------
  logic                         oq_push, oq_pop;
  logic [swam_pkg::START_W-1:0] oq_mem_r [swam_pkg::OQ_DEPTH];
  logic [OQPW-1:0]              oq_wr_r, oq_rd_r;
  logic [OQCW-1:0]              oq_cnt_r, oq_cnt_nxt;
  logic [1:0]                   pend;

  assign oq_push = (s2_op_r == swam_pkg::OP_TEXT) && s2_emit_r && (nz_nxt == '0);
  assign oq_pop  = out_word.valid && out_word.ready;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + OQCW'(1);
    end else if (!oq_push && oq_pop) begin
      oq_cnt_nxt = oq_cnt_r - OQCW'(1);
    end
  end

  // Hold input while words in flight could overfill the queue
  assign pend = 2'((s1_op_r == swam_pkg::OP_TEXT) && s1_emit_r)
              + 2'((s2_op_r == swam_pkg::OP_TEXT) && s2_emit_r);
  assign in_word.ready = (oq_cnt_r + OQCW'(pend)) < OQ_FULL;

  assign out_word.valid               = oq_cnt_r != '0;
  assign out_word.payload.start_index = oq_mem_r[oq_rd_r];

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= '0;
      tc_r       <= '0;
      rp_r       <= '0;
      ts_r       <= 1'b0;
      s1_op_r    <= swam_pkg::OP_NONE;
      s1_emit_r  <= 1'b0;
      s2_op_r    <= swam_pkg::OP_NONE;
      s2_emit_r  <= 1'b0;
      vx_r       <= '0;
      vy_r       <= '0;
      nz_r       <= '0;
      clr_prev_r <= 1'b0;
      wx_en_r    <= 1'b0;
      wy_en_r    <= 1'b0;
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_cnt_r   <= '0;
    end else begin
      pc_r       <= pc_nxt;
      tc_r       <= tc_nxt;
      rp_r       <= rp_nxt;
      ts_r       <= ts_nxt;
      s1_op_r    <= s1_op_nxt;
      s1_emit_r  <= s1_emit_nxt;
      s2_op_r    <= s1_op_r;
      s2_emit_r  <= s1_emit_r;
      vx_r       <= vx_nxt;
      vy_r       <= vy_nxt;
      nz_r       <= nz_nxt;
      clr_prev_r <= s2_op_r == swam_pkg::OP_CLEAR;
      wx_en_r    <= wx_en;
      wy_en_r    <= wy_en;
      oq_cnt_r   <= oq_cnt_nxt;
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + OQPW'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + OQPW'(1);
      end
    end
  end

  // Payload pipeline and write-back history
  always_ff @(posedge clk) begin
    s1_idx_r   <= s1_idx_nxt;
    s1_rem_r   <= s1_rem_nxt;
    s1_start_r <= s1_start_nxt;
    s2_n_r     <= s1_idx_r;
    s2_o_r     <= old_idx;
    s2_rem_r   <= s1_rem_r;
    s2_start_r <= s1_start_r;
    s2_vxn_r   <= vx_r[s1_idx_r];
    s2_vxo_r   <= vx_r[old_idx];
    s2_vyn_r   <= vy_r[s1_idx_r];
    s2_vyo_r   <= vy_r[old_idx];
    wx_addr_r  <= s2_n_r;
    wx_data_r  <= wx_data;
    wy_addr_r  <= s2_o_r;
    wy_data_r  <= wy_data;
    if (oq_push) begin
      oq_mem_r[oq_wr_r] <= s2_start_r;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SWAM_ASSERT_IMPLY(a_oq_no_overflow, oq_push && !oq_pop, oq_cnt_r < OQ_FULL, "output queue overflow")
  `SWAM_ASSERT_NEXT(a_clear_zeroes_nz, s2_op_r == swam_pkg::OP_CLEAR, (nz_r == '0) && (vx_r == '0), "clear left balance state")
  `SWAM_ASSERT_IMPLY(a_ring_ptr_bound, ts_r && (pc_r != '0), PCW'(rp_r) < pc_r, "ring pointer beyond pattern length")

endmodule

`default_nettype wire

>>> sim/anagram_match_checker.sv
// ----------------------------------------------------------------------------
// anagram_match_checker
// Watches both word channels of the sliding window anagram matcher, predicts
// the start index of every matching window from the accepted input words and
// compares each accepted result word against the oldest predicted start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module anagram_match_checker
  import swam_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  swam_chan_if  in_mon,
  swam_chan_if  out_mon,
  output int    mismatch_count,
  output int    pending_starts,
  output int    starts_seen,
  output int    words_seen
);

  // Search state: per-letter balance is window count minus pattern count
  logic signed [9:0]   balance [SWAM_ALPHABET];
  logic [4:0]          nonzero_cnt;
  int                  pat_len;
  int                  text_len;
  int                  ring_ptr;
  logic [LETTER_W-1:0] window_letters [SWAM_MAX_PATTERN];
  bit                  text_on;

  out_word_t expected_starts[$];

  initial begin
    mismatch_count = 0;
    pending_starts = 0;
    starts_seen    = 0;
    words_seen     = 0;
  end

  task automatic clear_search();
    foreach (balance[i]) balance[i] = '0;
    nonzero_cnt = '0;
    pat_len     = 0;
    text_len    = 0;
    ring_ptr    = 0;
    text_on     = 1'b0;
  endtask

  // Move one letter's balance and keep the nonzero tally in step
  task automatic bump_balance(input logic [LETTER_W-1:0] idx,
                              input logic signed [9:0] delta);
    logic signed [9:0] prior;
    prior        = balance[idx];
    balance[idx] = prior + delta;
    if (prior == 0 && balance[idx] != 0) begin
      nonzero_cnt = nonzero_cnt + 1'b1;
    end else if (prior != 0 && balance[idx] == 0) begin
      nonzero_cnt = nonzero_cnt - 1'b1;
    end
  endtask

  // Apply one accepted word; report the window start when it closes a match
  task automatic advance_search(input logic [REQ_W-1:0] req,
                                input logic [LETTER_W-1:0] letter,
                                output bit hit,
                                output logic [START_W-1:0] start);
    hit   = 1'b0;
    start = '0;
    case (req)
      REQ_CLEAR: begin
        clear_search();
      end
      REQ_PATTERN: begin
        if (letter < SWAM_ALPHABET && !text_on && pat_len < SWAM_MAX_PATTERN) begin
          bump_balance(letter, -10'sd1);
          pat_len++;
        end
      end
      REQ_TEXT: begin
        if (letter < SWAM_ALPHABET && text_len < SWAM_MAX_TEXT) begin
          text_on = 1'b1;
          if (pat_len == 0) begin
            text_len++;
          end else begin
            bump_balance(letter, 10'sd1);
            if (ring_ptr >= pat_len) ring_ptr = 0;
            // drop the letter leaving the window once it is full
            if (text_len >= pat_len) bump_balance(window_letters[ring_ptr], -10'sd1);
            window_letters[ring_ptr] = letter;
            ring_ptr++;
            if (ring_ptr >= pat_len) ring_ptr = 0;
            text_len++;
            if (text_len >= pat_len && nonzero_cnt == 0) begin
              hit   = 1'b1;
              start = START_W'(text_len - pat_len);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Check the result side first: a result never belongs to a same-edge input
  always @(posedge clk) begin : watch
    out_word_t            want;
    bit                   hit;
    logic [START_W-1:0]   start;
    if (!rst_n) begin
      clear_search();
      expected_starts.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        starts_seen++;
        if (expected_starts.size() == 0) begin
          log_mismatch($sformatf("start_index expected none got %0d",
                                 out_mon.payload.start_index));
        end else begin
          want = expected_starts.pop_front();
          if (want.start_index !== out_mon.payload.start_index) begin
            log_mismatch($sformatf("start_index expected %0d got %0d",
                                   want.start_index, out_mon.payload.start_index));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        words_seen++;
        advance_search(in_mon.payload.req_type, in_mon.payload.letter, hit, start);
        if (hit) expected_starts = {expected_starts, out_word_t'(start)};
      end
    end
    pending_starts = expected_starts.size();
  end

endmodule

>>> sim/tb_sliding_window_anagram_matcher.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_anagram_matcher
// Drives clear, pattern and text words into the anagram matcher under three
// idle mixes, with a long result-side stall and a maximum-length pattern;
// a separate checker predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_window_anagram_matcher;
  import swam_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int               RUN_LIMIT_NS = 400_000;

  typedef logic [LETTER_W-1:0] letter_q_t[$];

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int sink_hold     = 0;
  int words_driven  = 0;
  int noise_driven  = 0;

  int mismatch_count;
  int pending_starts;
  int starts_seen;
  int words_seen;

  swam_chan_if #(.payload_t(in_word_t))  in_ch ();
  swam_chan_if #(.payload_t(out_word_t)) out_ch ();

  sliding_window_anagram_matcher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  anagram_match_checker u_match_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .pending_starts (pending_starts),
    .starts_seen    (starts_seen),
    .words_seen     (words_seen)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random back-pressure, or a counted hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Hard stop
  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // Offer one word from a falling edge and hold it until accepted
  task automatic push_word(input logic [REQ_W-1:0] rq, input logic [LETTER_W-1:0] lt);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.payload.req_type <= rq;
    in_ch.payload.letter   <= lt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_driven++;
    @(negedge clk);
  endtask

  // Unused request code or a letter outside the alphabet
  task automatic push_noise();
    case ($urandom_range(2))
      0:       push_word(REQ_UNUSED, LETTER_W'($urandom));
      1:       push_word(REQ_PATTERN, LETTER_W'($urandom_range(SWAM_ALPHABET, 31)));
      default: push_word(REQ_TEXT, LETTER_W'($urandom_range(SWAM_ALPHABET, 31)));
    endcase
    noise_driven++;
  endtask

  task automatic maybe_noise();
    if ($urandom_range(99) < 4) push_noise();
  endtask

  // Hold the input idle until every predicted start has come back
  task automatic pause_for_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_starts != 0) @(negedge clk);
  endtask

  function automatic letter_q_t shuffle_letters(letter_q_t src);
    letter_q_t           dst;
    logic [LETTER_W-1:0] tmp;
    int                  j;
    dst = src;
    for (int i = dst.size() - 1; i > 0; i--) begin
      j      = $urandom_range(0, i);
      tmp    = dst[i];
      dst[i] = dst[j];
      dst[j] = tmp;
    end
    return dst;
  endfunction

  task automatic send_text_run(letter_q_t run);
    foreach (run[i]) push_word(REQ_TEXT, run[i]);
  endtask

  // One well-formed search: clear, pattern, then text rich in anagrams
  task automatic random_search();
    letter_q_t pat;
    int        plen;
    int        lo;
    int        span;
    int        text_goal;
    int        sent;
    int        roll;
    push_word(REQ_CLEAR, LETTER_W'($urandom));
    roll = $urandom_range(99);
    if (roll < 6) plen = 0;
    else if (roll < 88) plen = $urandom_range(1, 6);
    else plen = $urandom_range(7, 40);
    // narrow letter sets make anagrams common; sometimes use all letters
    if ($urandom_range(99) < 20) begin
      lo   = 0;
      span = SWAM_ALPHABET;
    end else begin
      span = $urandom_range(1, 4);
      lo   = $urandom_range(0, SWAM_ALPHABET - span);
    end
    for (int i = 0; i < plen; i++) begin
      maybe_noise();
      pat = {pat, LETTER_W'(lo + $urandom_range(0, span - 1))};
      push_word(REQ_PATTERN, pat[i]);
    end
    text_goal = $urandom_range(plen + 2, 4 * plen + 10);
    sent      = 0;
    while (sent < text_goal) begin
      maybe_noise();
      roll = $urandom_range(99);
      if (plen > 0 && roll < 45) begin
        send_text_run(shuffle_letters(pat));
        sent += plen;
      end else if (sent > 0 && roll < 50) begin
        // late pattern letter, dropped by the block
        push_word(REQ_PATTERN, LETTER_W'(lo + $urandom_range(0, span - 1)));
      end else begin
        push_word(REQ_TEXT, LETTER_W'(lo + $urandom_range(0, span - 1)));
        sent++;
      end
    end
  endtask

  task automatic run_random(input int budget);
    int target;
    target = (words_driven - noise_driven) + budget;
    while ((words_driven - noise_driven) < target) random_search();
  endtask

  // Directed: letter extremes, every request, ignored bad or late letters
  task automatic run_directed();
    push_word(REQ_CLEAR, 5'd31);
    push_word(REQ_PATTERN, 5'd25);
    push_word(REQ_PATTERN, 5'd0);
    push_word(REQ_TEXT, 5'd0);
    push_word(REQ_TEXT, 5'd25);
    push_word(REQ_TEXT, 5'd25);
    push_word(REQ_TEXT, 5'd0);
    push_word(REQ_PATTERN, 5'd3);
    push_word(REQ_TEXT, 5'd31);
    push_word(REQ_UNUSED, 5'd5);
    push_word(REQ_TEXT, 5'd26);
    push_word(REQ_TEXT, 5'd25);
    // empty pattern: text counted, nothing reported
    push_word(REQ_CLEAR, 5'd0);
    push_word(REQ_TEXT, 5'd7);
    push_word(REQ_TEXT, 5'd7);
    push_word(REQ_PATTERN, 5'd7);
    // out-of-alphabet pattern letters are dropped
    push_word(REQ_CLEAR, 5'd10);
    push_word(REQ_PATTERN, 5'd31);
    push_word(REQ_PATTERN, 5'd26);
    push_word(REQ_PATTERN, 5'd1);
    push_word(REQ_TEXT, 5'd1);
    push_word(REQ_UNUSED, 5'd31);
    push_word(REQ_UNUSED, 5'd0);
  endtask

  // Stall the result side while single-letter matches keep arriving
  task automatic run_backpressure();
    push_word(REQ_CLEAR, 5'd0);
    push_word(REQ_PATTERN, 5'd4);
    sink_hold = 250;
    repeat (40) push_word(REQ_TEXT, 5'd4);
    pause_for_results();
  endtask

  // Full-size pattern plus one letter beyond the limit
  task automatic run_long_pattern();
    letter_q_t pat;
    push_word(REQ_CLEAR, 5'd0);
    for (int i = 0; i < SWAM_MAX_PATTERN; i++) begin
      pat = {pat, LETTER_W'($urandom_range(0, 2))};
      push_word(REQ_PATTERN, pat[i]);
    end
    push_word(REQ_PATTERN, 5'd25);
    send_text_run(shuffle_letters(pat));
    repeat (16) push_word(REQ_TEXT, LETTER_W'($urandom_range(0, 2)));
    pause_for_results();
  endtask

  // Stimulus and verdict
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // slow sender, very slow receiver
    src_idle_pct  = 23;
    sink_idle_pct = 72;
    run_directed();
    run_random(200);
    run_backpressure();

    // very slow sender, slow receiver
    src_idle_pct  = 72;
    sink_idle_pct = 23;
    run_random(200);
    run_long_pattern();

    // full rate both ways
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(200);

    pause_for_results();
    repeat (8) @(negedge clk);

    $display("covered %0d input words, %0d of them malformed, and %0d match results",
             words_seen, noise_driven, starts_seen);
    $display("idle mixes 23/72, 72/23 and none, a 250-cycle result stall ",
             "and a full-size pattern with one letter past its limit");
    if (mismatch_count == 0 && pending_starts == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
